>>> sv/hte_pkg.sv
// Shared types, entity tables and string helpers for the HTML text escaper.
package hte_pkg;

  // One source byte with its end-of-string flag.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_end;
  } in_item_t;

  // One escaped output byte with its framing flags.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_done;
  } out_item_t;

  localparam int unsigned NumSfx  = 6;
  localparam int unsigned SfxMax  = 5;
  localparam int unsigned HeldMax = 5;

  localparam logic [7:0] CharAmp  = 8'h26;
  localparam logic [7:0] CharLt   = 8'h3C;
  localparam logic [7:0] CharGt   = 8'h3E;
  localparam logic [7:0] CharQuot = 8'h22;
  localparam logic [7:0] CharApos = 8'h27;

  // Entity bodies that may follow an ampersand: lt; gt; amp; quot; apos; #
  localparam logic [7:0] SfxText [NumSfx][SfxMax] = '{
    '{8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
    '{8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
    '{8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
    '{8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},
    '{8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B},
    '{8'h23, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] SfxLen [NumSfx] = '{3'd3, 3'd3, 3'd4, 3'd5, 3'd5, 3'd1};

  localparam logic [39:0] AmpEntity  = "&amp;";
  localparam logic [31:0] LtEntity   = "&lt;";
  localparam logic [31:0] GtEntity   = "&gt;";
  localparam logic [47:0] QuotEntity = "&quot;";
  localparam logic [47:0] AposEntity = "&apos;";

  // What precedes the held bytes in a command.
  typedef enum logic [1:0] {
    PreNone,
    PreChar,
    PreEntity
  } pre_e;

  // What follows the held bytes in a command.
  typedef enum logic [2:0] {
    TailNone,
    TailByte,
    TailLt,
    TailGt,
    TailQuot,
    TailApos,
    TailAmp
  } tail_e;

  // One work command: a prefix, up to five held bytes, and a tail.
  typedef struct packed {
    pre_e            pre;
    logic [2:0]      held_n;
    logic [4:0][7:0] held;
    tail_e           tail;
    logic [7:0]      tail_byte;
    logic            last_of_string;
  } cmd_t;

  function automatic logic [2:0] pre_len(pre_e p);
    logic [2:0] len;
    unique case (p)
      PreNone:   len = 3'd0;
      PreChar:   len = 3'd1;
      PreEntity: len = 3'd5;
      default:   len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] pre_byte(pre_e p, logic [2:0] idx);
    logic [7:0] b;
    unique case (p)
      PreEntity: b = AmpEntity[8 * (4 - int'(idx)) +: 8];
      default:   b = CharAmp;
    endcase
    return b;
  endfunction

  function automatic logic [2:0] tail_len(tail_e t);
    logic [2:0] len;
    unique case (t)
      TailNone: len = 3'd0;
      TailByte: len = 3'd1;
      TailLt:   len = 3'd4;
      TailGt:   len = 3'd4;
      TailQuot: len = 3'd6;
      TailApos: len = 3'd6;
      TailAmp:  len = 3'd5;
      default:  len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] tail_char(tail_e t, logic [7:0] raw, logic [2:0] idx);
    logic [7:0] b;
    unique case (t)
      TailLt:   b = LtEntity[8 * (3 - int'(idx)) +: 8];
      TailGt:   b = GtEntity[8 * (3 - int'(idx)) +: 8];
      TailQuot: b = QuotEntity[8 * (5 - int'(idx)) +: 8];
      TailApos: b = AposEntity[8 * (5 - int'(idx)) +: 8];
      TailAmp:  b = AmpEntity[8 * (4 - int'(idx)) +: 8];
      default:  b = raw;
    endcase
    return b;
  endfunction

endpackage

>>> sv/html_text_escaper.sv
// Top level of the streaming HTML text escaper.
//
// Source text enters one byte per item on the push/full queue port, with
// in_end set on the final byte of a string. Escaped bytes leave on the
// empty/pop queue port; run_last marks the last byte caused by one source
// byte and string_done the final byte of the escaped string.
// The front end classifies each accepted byte combinationally and writes a
// command into a QueueDepth-entry queue; bytes that start or extend an
// ampersand run are held and write nothing. The back end turns the head
// command into output bytes, one per cycle unless the receiver stalls,
// into an output register. One item is accepted per cycle while each
// yields at most one byte and the receiver keeps up; an item can yield
// up to 15 bytes, and full rises once the queue fills behind it.
// When the receiver stalls, the output register holds its byte and the
// queue absorbs up to QueueDepth more commands before full stalls the input.
// Reset clears the held run, the queue and the output valid flag.
module html_text_escaper #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  hte_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output hte_pkg::out_item_t out_item_o
);

  logic          accept;
  logic          cmd_push;
  hte_pkg::cmd_t cmd_in;
  hte_pkg::cmd_t cmd_head;
  logic          q_empty;
  logic          q_pop;
  logic          out_valid;

  // An item is taken only while the command queue has room.
  assign accept = push && !full;
  assign empty  = !out_valid;

  hte_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_item_i  (in_item_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  hte_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (cmd_head)
  );

  // The back end sees pop only while a byte is actually offered.
  hte_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (q_pop),
    .out_pop_i   (pop && out_valid),
    .out_valid_o (out_valid),
    .out_item_o  (out_item_o)
  );

`ifndef ASSERT_OFF
  // A command is never written into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_push |-> !full)
    else $error("command written into a full queue");

  // The back end only retires a command that is present.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("command retired from an empty queue");

  // The final byte of a string is always the last byte of its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.string_done) |-> out_item_o.run_last)
    else $error("string_done without run_last");
`endif

endmodule

>>> sv/hte_front.sv
// Front end: tracks ampersand runs, matches entities and issues work commands.
module hte_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  hte_pkg::in_item_t in_item_i,
  output logic              cmd_push_o,
  output hte_pkg::cmd_t     cmd_o
);

  logic       hold_active_q, hold_active_d;
  logic [2:0] hold_count_q, hold_count_d;
  logic [7:0] held_q [4];

  logic [7:0]                  b;
  logic                        last;
  logic [2:0]                  n;
  logic [4:0][7:0]             cand;
  logic [hte_pkg::NumSfx-1:0]  match;
  logic [hte_pkg::NumSfx-1:0]  complete;
  logic                        store;
  hte_pkg::tail_e              fresh_tail;
  logic                        fresh_hold;

  assign b    = in_item_i.in_byte;
  assign last = in_item_i.in_end;
  assign n    = hold_count_q + 3'd1;

  // Candidate run: the held bytes followed by the new byte.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cand[i] = (3'(i) < hold_count_q) ? held_q[i] : b;
    end
    cand[4] = b;
  end

  always_comb begin
    logic m;
    for (int k = 0; k < hte_pkg::NumSfx; k++) begin
      m = 1'b1;
      for (int i = 0; i < hte_pkg::SfxMax; i++) begin
        if (3'(i) < n && cand[i] != hte_pkg::SfxText[k][i]) begin
          m = 1'b0;
        end
      end
      match[k]    = m && (n <= hte_pkg::SfxLen[k]);
      complete[k] = match[k] && (n == hte_pkg::SfxLen[k]);
    end
  end

  // Treatment of a byte outside any held run.
  always_comb begin
    fresh_hold = 1'b0;
    unique case (b)
      hte_pkg::CharLt:   fresh_tail = hte_pkg::TailLt;
      hte_pkg::CharGt:   fresh_tail = hte_pkg::TailGt;
      hte_pkg::CharQuot: fresh_tail = hte_pkg::TailQuot;
      hte_pkg::CharApos: fresh_tail = hte_pkg::TailApos;
      hte_pkg::CharAmp: begin
        // A final ampersand is flushed as an entity right away.
        fresh_tail = last ? hte_pkg::TailAmp : hte_pkg::TailNone;
        fresh_hold = !last;
      end
      default:           fresh_tail = hte_pkg::TailByte;
    endcase
  end

  always_comb begin
    cmd_o.pre            = hte_pkg::PreNone;
    cmd_o.held_n         = 3'd0;
    cmd_o.held           = cand;
    cmd_o.tail           = fresh_tail;
    cmd_o.tail_byte      = b;
    cmd_o.last_of_string = last;
    hold_active_d        = fresh_hold;
    hold_count_d         = 3'd0;
    store                = 1'b0;
    if (hold_active_q) begin
      if (|complete) begin
        cmd_o.pre     = hte_pkg::PreChar;
        cmd_o.held_n  = n;
        cmd_o.tail    = hte_pkg::TailNone;
        hold_active_d = 1'b0;
      end else if (|match) begin
        cmd_o.tail = hte_pkg::TailNone;
        if (last) begin
          cmd_o.pre     = hte_pkg::PreEntity;
          cmd_o.held_n  = n;
          hold_active_d = 1'b0;
        end else begin
          hold_active_d = 1'b1;
          hold_count_d  = n;
          store         = 1'b1;
        end
      end else begin
        // Broken run: escape the ampersand, replay the matched bytes,
        // then treat the breaking byte afresh.
        cmd_o.pre    = hte_pkg::PreEntity;
        cmd_o.held_n = hold_count_q;
      end
    end
    cmd_push_o = accept_i && (cmd_o.pre != hte_pkg::PreNone ||
                              cmd_o.tail != hte_pkg::TailNone);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_active_q <= 1'b0;
      hold_count_q  <= 3'd0;
    end else if (accept_i) begin
      hold_active_q <= hold_active_d;
      hold_count_q  <= hold_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && store) begin
      held_q[hold_count_q[1:0]] <= b;
    end
  end

endmodule

>>> sv/hte_fifo.sv
// Short command queue between the front end and the back end.
module hte_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hte_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output hte_pkg::cmd_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hte_pkg::cmd_t     mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

>>> sv/hte_back.sv
// Back end: expands each command into output bytes, one per cycle unless the receiver stalls.
module hte_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  hte_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  input  logic               out_pop_i,
  output logic               out_valid_o,
  output hte_pkg::out_item_t out_item_o
);

  logic [3:0]         pos_q;
  logic               out_valid_q;
  hte_pkg::out_item_t out_q;

  logic [3:0] pre_l, held_l, tail_l, total;
  logic [3:0] held_idx, tail_idx;
  logic [7:0] byte_d;
  logic       last;
  logic       adv;

  assign pre_l    = {1'b0, hte_pkg::pre_len(cmd_i.pre)};
  assign held_l   = {1'b0, cmd_i.held_n};
  assign tail_l   = {1'b0, hte_pkg::tail_len(cmd_i.tail)};
  assign total    = pre_l + held_l + tail_l;
  assign held_idx = pos_q - pre_l;
  assign tail_idx = pos_q - pre_l - held_l;
  assign last     = (pos_q == total - 4'd1);
  assign adv      = cmd_valid_i && (!out_valid_q || out_pop_i);

  always_comb begin
    if (pos_q < pre_l) begin
      byte_d = hte_pkg::pre_byte(cmd_i.pre, pos_q[2:0]);
    end else if (pos_q < pre_l + held_l) begin
      byte_d = cmd_i.held[held_idx[2:0]];
    end else begin
      byte_d = hte_pkg::tail_char(cmd_i.tail, cmd_i.tail_byte, tail_idx[2:0]);
    end
  end

  assign cmd_pop_o   = adv && last;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        pos_q       <= last ? 4'd0 : pos_q + 4'd1;
        out_valid_q <= 1'b1;
      end else if (out_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.out_byte    <= byte_d;
      out_q.run_last    <= last;
      out_q.string_done <= last && cmd_i.last_of_string;
    end
  end

endmodule
